// ===== sv/implicit_penalization_cell_update_assert.svh =====
// Assertion macros shared by the penalization cell update modules.
`ifndef IMPLICIT_PENALIZATION_CELL_UPDATE_ASSERT_SVH
`define IMPLICIT_PENALIZATION_CELL_UPDATE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPCU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPCU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ipcu_pkg.sv =====
// Types, constants and helper functions of the penalization cell update block.
package ipcu_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int CHI_WIDTH   = 17;
   localparam int CSR_WIDTH   = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int DEN_WIDTH   = 50;
   localparam int QUOT_WIDTH  = 31;
   localparam int REM_WIDTH   = 64;
   localparam int DIV_STEPS   = QUOT_WIDTH;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int REQ_BITS    = 2 * CHI_WIDTH + 6 * DATA_WIDTH;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = 2 * DATA_WIDTH;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LAMBDA_DT  = 3'd0,
      CSR_BODY_U     = 3'd1,
      CSR_BODY_V     = 3'd2,
      CSR_BODY_OMEGA = 3'd3,
      CSR_CENTER_X   = 3'd4,
      CSR_CENTER_Y   = 3'd5
   } csr_index_type;

   // Per-cell values that ride along with the divider.
   typedef struct packed {
      logic                         pen;
      logic signed [DATA_WIDTH-1:0] fu;
      logic signed [DATA_WIDTH-1:0] fv;
      logic signed [DATA_WIDTH-1:0] us;
      logic signed [DATA_WIDTH-1:0] vs;
   } carry_type;

   // One queue entry: carried values plus the blend denominator.
   typedef struct packed {
      carry_type             carry;
      logic [DEN_WIDTH-1:0]  den;
   } entry_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   // Saturate a wide signed value to the data range.
   function automatic logic signed [DATA_WIDTH-1:0] sat_data(input logic signed [63:0] x);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (x > hi) begin
         sat_data = hi[DATA_WIDTH-1:0];
      end else if (x < lo) begin
         sat_data = lo[DATA_WIDTH-1:0];
      end else begin
         sat_data = x[DATA_WIDTH-1:0];
      end
   endfunction

endpackage

// ===== sv/ipcu_front.sv =====
// Front: configuration registers, cell classification and solid velocity.
module ipcu_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [ipcu_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                  csr_we,
   input  logic [ipcu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ipcu_pkg::CSR_WIDTH-1:0]        csr_wdata,
   input  ipcu_pkg::queue_status_type            q_status,
   output logic                                  push,
   output ipcu_pkg::entry_type                   push_entry
);

   localparam int DW = ipcu_pkg::DATA_WIDTH;
   localparam int CW = ipcu_pkg::CHI_WIDTH;

   logic [DW-1:0] lambda_dt_ff;
   logic signed [DW-1:0] body_u_ff, body_v_ff, body_omega_ff, center_x_ff, center_y_ff;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_dt_ff  <= '0;
         body_u_ff     <= '0;
         body_v_ff     <= '0;
         body_omega_ff <= '0;
         center_x_ff   <= '0;
         center_y_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ipcu_pkg::CSR_LAMBDA_DT:  lambda_dt_ff  <= csr_wdata;
            ipcu_pkg::CSR_BODY_U:     body_u_ff     <= csr_wdata;
            ipcu_pkg::CSR_BODY_V:     body_v_ff     <= csr_wdata;
            ipcu_pkg::CSR_BODY_OMEGA: body_omega_ff <= csr_wdata;
            ipcu_pkg::CSR_CENTER_X:   center_x_ff   <= csr_wdata;
            ipcu_pkg::CSR_CENTER_Y:   center_y_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Unpack the request fields.
   logic [CW-1:0] gchi, ochi;
   logic signed [DW-1:0] fu, fv, px, py, du, dv;
   assign gchi = req_tdata[CW-1:0];
   assign ochi = req_tdata[2*CW-1:CW];
   assign fu   = req_tdata[2*CW+1*DW-1:2*CW+0*DW];
   assign fv   = req_tdata[2*CW+2*DW-1:2*CW+1*DW];
   assign px   = req_tdata[2*CW+3*DW-1:2*CW+2*DW];
   assign py   = req_tdata[2*CW+4*DW-1:2*CW+3*DW];
   assign du   = req_tdata[2*CW+5*DW-1:2*CW+4*DW];
   assign dv   = req_tdata[2*CW+6*DW-1:2*CW+5*DW];

   // Accept only while the queue has room for everything in flight here.
   logic v1_ff, v2_ff;
   logic [ipcu_pkg::QCNT_W:0] credit_use;
   logic accept;
   assign credit_use = {1'b0, q_status.count} + {{ipcu_pkg::QCNT_W{1'b0}}, v1_ff}
                     + {{ipcu_pkg::QCNT_W{1'b0}}, v1_ff & 1'b0} + {{ipcu_pkg::QCNT_W{1'b0}}, v2_ff};
   assign req_tready = credit_use < (ipcu_pkg::QCNT_W+1)'(ipcu_pkg::QUEUE_DEPTH);
   assign accept = req_tvalid && req_tready;

   // Stage 1: classify, offsets from the center and the blend coefficient.
   logic pen_in;
   logic signed [DW:0] dx_in, dy_in;
   logic [DW+CW-1:0] k_in;
   assign pen_in = (ochi != '0) && (gchi <= ochi);
   assign dx_in  = {px[DW-1], px} - {center_x_ff[DW-1], center_x_ff};
   assign dy_in  = {py[DW-1], py} - {center_y_ff[DW-1], center_y_ff};
   assign k_in   = lambda_dt_ff * ochi;

   logic pen1_ff;
   logic signed [DW-1:0] fu1_ff, fv1_ff, du1_ff, dv1_ff;
   logic signed [DW:0] dx1_ff, dy1_ff;
   logic [DW+CW-1:0] k1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      pen1_ff <= pen_in;
      fu1_ff  <= fu;
      fv1_ff  <= fv;
      du1_ff  <= du;
      dv1_ff  <= dv;
      dx1_ff  <= dx_in;
      dy1_ff  <= dy_in;
      k1_ff   <= k_in;
   end

   // Stage 2: rotation products and the denominator.
   logic signed [2*DW:0] px_in, py_in;
   assign px_in = body_omega_ff * dx1_ff;
   assign py_in = body_omega_ff * dy1_ff;

   logic pen2_ff;
   logic signed [DW-1:0] fu2_ff, fv2_ff, du2_ff, dv2_ff;
   logic signed [2*DW:0] prodx2_ff, prody2_ff;
   logic [ipcu_pkg::DEN_WIDTH-1:0] den2_ff;

   always_ff @(posedge clock) begin
      pen2_ff   <= pen1_ff;
      fu2_ff    <= fu1_ff;
      fv2_ff    <= fv1_ff;
      du2_ff    <= du1_ff;
      dv2_ff    <= dv1_ff;
      prodx2_ff <= px_in;
      prody2_ff <= py_in;
      den2_ff   <= (ipcu_pkg::DEN_WIDTH)'(k1_ff) + ((ipcu_pkg::DEN_WIDTH)'(1) << 32);
   end

   // Round the products half up and form the saturated solid velocity.
   logic signed [2*DW:0] rx_sum, ry_sum;
   logic signed [63:0] rot_x, rot_y, us_wide, vs_wide;
   assign rx_sum  = prodx2_ff + (2*DW+1)'(32768);
   assign ry_sum  = prody2_ff + (2*DW+1)'(32768);
   assign rot_x   = 64'(signed'(rx_sum[2*DW:16]));
   assign rot_y   = 64'(signed'(ry_sum[2*DW:16]));
   assign us_wide = 64'(body_u_ff) - rot_y + 64'(du2_ff);
   assign vs_wide = 64'(body_v_ff) + rot_x + 64'(dv2_ff);

   assign push                   = v2_ff;
   assign push_entry.carry.pen   = pen2_ff;
   assign push_entry.carry.fu    = fu2_ff;
   assign push_entry.carry.fv    = fv2_ff;
   assign push_entry.carry.us    = ipcu_pkg::sat_data(us_wide);
   assign push_entry.carry.vs    = ipcu_pkg::sat_data(vs_wide);
   assign push_entry.den         = den2_ff;

endmodule

// ===== sv/ipcu_queue.sv =====
// Short queue between the front and the back.
`include "implicit_penalization_cell_update_assert.svh"

module ipcu_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  ipcu_pkg::entry_type         push_entry,
   input  logic                        pop,
   output ipcu_pkg::entry_type         head,
   output ipcu_pkg::queue_status_type  status
);

   ipcu_pkg::entry_type mem [ipcu_pkg::QUEUE_DEPTH];
   ipcu_pkg::entry_type head_ff, head_in;
   logic [ipcu_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ipcu_pkg::QCNT_W-1:0] count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // The head register follows the next read slot; a transfer in to that slot is passed through.
   always_comb begin
      head_in = mem[rd_ptr_in];
      if (push && (wr_ptr_ff == rd_ptr_in)) begin
         head_in = push_entry;
      end
   end

   // Entry storage and registered head read.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
      head_ff <= head_in;
   end

   assign head         = head_ff;
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);

   `IPCU_ASSERT_SAME(a_no_overflow, clock, reset, push && !pop, count_ff < (ipcu_pkg::QCNT_W)'(ipcu_pkg::QUEUE_DEPTH), "queue overflow")
   `IPCU_ASSERT_SAME(a_no_underflow, clock, reset, pop, count_ff != '0, "queue underflow")
   `IPCU_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not rise on a transfer in")

endmodule

// ===== sv/ipcu_back.sv =====
// Back: pipelined divider for alpha, blend toward the solid velocity, output register.
`include "implicit_penalization_cell_update_assert.svh"

module ipcu_back (
   input  logic                                clock,
   input  logic                                reset,
   input  ipcu_pkg::entry_type                 head,
   input  ipcu_pkg::queue_status_type          q_status,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ipcu_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tuser
);

   localparam int DW    = ipcu_pkg::DATA_WIDTH;
   localparam int NS    = ipcu_pkg::DIV_STEPS;
   localparam int RW    = ipcu_pkg::REM_WIDTH;
   localparam int QW    = ipcu_pkg::QUOT_WIDTH;
   localparam int DENW  = ipcu_pkg::DEN_WIDTH;
   localparam int CMPW  = DENW + QW;

   // The whole back pipeline moves when the output register is free or drained.
   logic out_v_ff;
   logic en;
   assign en  = !out_v_ff || rsp_tready;
   assign pop = en && !q_status.empty;

   // Divider stages: stage 0 holds the dividend, stage s+1 has one more quotient bit.
   logic                  dv_ff   [NS+1];
   logic [RW-1:0]         rem_ff  [NS+1];
   logic [QW-1:0]         quo_ff  [NS+1];
   logic [DENW-1:0]       den_ff  [NS+1];
   ipcu_pkg::carry_type   car_ff  [NS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= (RW'(1) << 62) + RW'(head.den[DENW-1:1]);
         quo_ff[0] <= '0;
         den_ff[0] <= head.den;
         car_ff[0] <= head.carry;
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_div
      localparam int Bit = QW - 1 - s;
      logic [CMPW-1:0] dsh;
      logic            fits;
      logic [RW-1:0]   rem_in;
      logic [QW-1:0]   quo_in;

      // One restoring step: try the divisor at this quotient bit.
      always_comb begin
         dsh    = CMPW'(den_ff[s]) << Bit;
         fits   = CMPW'(rem_ff[s]) >= dsh;
         rem_in = fits ? rem_ff[s] - dsh[RW-1:0] : rem_ff[s];
         quo_in = quo_ff[s];
         quo_in[Bit] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s+1] <= 1'b0;
         end else if (en) begin
            dv_ff[s+1] <= dv_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= rem_in;
            quo_ff[s+1] <= quo_in;
            den_ff[s+1] <= den_ff[s];
            car_ff[s+1] <= car_ff[s];
         end
      end
   end

   // Multiply stage: alpha times the velocity difference for both components.
   logic signed [DW:0]    diffu, diffv;
   logic signed [QW:0]    alpha_s;
   logic signed [2*DW:0]  produ_in, prodv_in;
   assign alpha_s  = signed'({1'b0, quo_ff[NS]});
   assign diffu    = {car_ff[NS].fu[DW-1], car_ff[NS].fu} - {car_ff[NS].us[DW-1], car_ff[NS].us};
   assign diffv    = {car_ff[NS].fv[DW-1], car_ff[NS].fv} - {car_ff[NS].vs[DW-1], car_ff[NS].vs};
   assign produ_in = alpha_s * diffu;
   assign prodv_in = alpha_s * diffv;

   logic                  mv_ff;
   logic signed [2*DW:0]  produ_ff, prodv_ff;
   ipcu_pkg::carry_type   mcar_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         mv_ff    <= dv_ff[NS];
         out_v_ff <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         produ_ff <= produ_in;
         prodv_ff <= prodv_in;
         mcar_ff  <= car_ff[NS];
      end
   end

   // Round the correction, add it to the solid velocity and saturate; cells outside the body pass the fluid velocity.
   logic signed [2*DW:0] ru, rv;
   logic signed [63:0]   nu_wide, nv_wide;
   logic signed [DW-1:0] nu_in, nv_in;
   assign ru      = produ_ff + (2*DW+1)'(1 << 29);
   assign rv      = prodv_ff + (2*DW+1)'(1 << 29);
   assign nu_wide = 64'(mcar_ff.us) + 64'(signed'(ru[2*DW:30]));
   assign nv_wide = 64'(mcar_ff.vs) + 64'(signed'(rv[2*DW:30]));
   assign nu_in   = mcar_ff.pen ? ipcu_pkg::sat_data(nu_wide) : mcar_ff.fu;
   assign nv_in   = mcar_ff.pen ? ipcu_pkg::sat_data(nv_wide) : mcar_ff.fv;

   logic [DW-1:0] new_u_ff, new_v_ff;
   logic          upd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         new_u_ff <= nu_in;
         new_v_ff <= nv_in;
         upd_ff   <= mcar_ff.pen;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {new_v_ff, new_u_ff};
   assign rsp_tuser  = upd_ff;

   `IPCU_ASSERT_SAME(a_alpha_range, clock, reset, dv_ff[NS], quo_ff[NS] <= (QW'(1) << (QW - 1)), "alpha above one")
   `IPCU_ASSERT_SAME(a_pop_nonempty, clock, reset, pop, !q_status.empty && en, "pop without data or while stalled")
   `IPCU_ASSERT_NEXT(a_stall_holds, clock, reset, out_v_ff && !rsp_tready, mv_ff == $past(mv_ff) && dv_ff[NS] == $past(dv_ff[NS]), "back pipeline moved while stalled")

endmodule

// ===== sv/implicit_penalization_cell_update.sv =====
// Top level of the implicit penalization cell update block.
// Takes one grid cell per clock on the req stream while req_tready is high and returns its
// updated velocity on the rsp stream, one result per cell, in order. Throughput is one
// cell per cycle while the queue has room and rsp is not stalled. A req transfer passes
// the first and second front stages, the queue write, the dividend load, 31 divider steps
// of one quotient bit each, one multiply stage and the output register on its way to rsp.
// The 31-step pipelined divider for alpha is most of that path. An 8-entry queue splits
// the front from the back, so the req side keeps taking cells while rsp is stalled until the
// queue fills. Write the csr registers only while no cell is in flight.
module implicit_penalization_cell_update (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // grid_chi[16:0], obstacle_chi[33:17], fluid_u, fluid_v, pos_x, pos_y, deform_u, deform_v
   input  logic [ipcu_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // new_u[31:0], new_v[63:32]
   output logic [ipcu_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // was_updated[0]
   output logic                                 rsp_tuser,
   input  logic                                 csr_we,
   input  logic [ipcu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ipcu_pkg::CSR_WIDTH-1:0]       csr_wdata
);

   ipcu_pkg::queue_status_type q_status;
   ipcu_pkg::entry_type        push_entry, head;
   logic                       push, pop;

   ipcu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   ipcu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   ipcu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
